FILE: rtl/imu_fp_pkg.sv
// Package for the IMU frame parser: beat types, frame constants and result codes.
// No dependencies; every other file in rtl/ imports it.
`timescale 1ns / 1ps
`default_nettype none

package imu_fp_pkg;

    // Frame layout constants
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_OMEGA = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [3:0] POS_TYPE   = 4'd1;
    localparam logic [3:0] POS_DATA0  = 4'd2;
    localparam logic [3:0] POS_LAST   = 4'd9;
    localparam logic [3:0] POS_SUM    = 4'd10;

    // Input beat kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_HDR_ERR  = 2'd1;
    localparam logic [1:0] ST_SUM_ERR  = 2'd2;
    localparam logic [1:0] ST_TYPE_ERR = 2'd3;

    // Default depth of the result queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         frame_type;
        logic signed [15:0] value_x;
        logic signed [15:0] value_y;
        logic signed [15:0] value_z;
        logic signed [15:0] temperature_raw;
    } out_item_t;

    // Result handed from the front part to the queue
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_push_t;

endpackage : imu_fp_pkg

`default_nettype wire

FILE: rtl/imu_fp_front.sv
// Front part of the IMU frame parser: header hunt, byte position, checksum and type check.
// Depends on imu_fp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imu_fp_front
    import imu_fp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      beat,
    input  wire in_item_t  in_item,
    output res_push_t      push
);

    logic       aligned_reg, aligned_next;
    logic [3:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] payload_reg [8];
    logic       pay_we;
    logic [2:0] pay_idx;
    logic [7:0] b;
    logic [7:0] sum_add;
    logic [1:0] ftype_code;

    assign b          = in_item.rx_byte;
    assign sum_add    = sum_reg + b;
    assign pay_idx    = 3'(pos_reg - POS_DATA0);
    assign ftype_code = 2'(type_reg - TYPE_ACCEL);

    always_comb
    begin
        aligned_next = aligned_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        type_next    = type_reg;
        pay_we       = 1'b0;
        push         = '0;
        if (beat)
        begin
            if (in_item.kind == KIND_ERROR)
            begin
                // drop the partial frame and hunt
                aligned_next = 1'b0;
                pos_next     = '0;
                sum_next     = '0;
            end
            else if (!aligned_reg)
            begin
                if (b == HDR_BYTE)
                begin
                    aligned_next = 1'b1;
                    pos_next     = POS_TYPE;
                    sum_next     = HDR_BYTE;
                end
            end
            else if (pos_reg == '0)
            begin
                if (b == HDR_BYTE)
                begin
                    pos_next = POS_TYPE;
                    sum_next = HDR_BYTE;
                end
                else
                begin
                    aligned_next     = 1'b0;
                    sum_next         = '0;
                    push.valid       = 1'b1;
                    push.item.status = ST_HDR_ERR;
                end
            end
            else if (pos_reg == POS_TYPE)
            begin
                type_next = b;
                sum_next  = sum_add;
                pos_next  = POS_DATA0;
            end
            else if (pos_reg <= POS_LAST)
            begin
                pay_we   = 1'b1;
                sum_next = sum_add;
                pos_next = pos_reg + 4'd1;
            end
            else
            begin
                // checksum byte
                push.valid = 1'b1;
                pos_next   = '0;
                sum_next   = '0;
                if (sum_reg != b)
                begin
                    aligned_next     = 1'b0;
                    push.item.status = ST_SUM_ERR;
                end
                else if (type_reg inside {TYPE_ACCEL, TYPE_OMEGA, TYPE_ANGLE})
                begin
                    push.item.status          = ST_OK;
                    push.item.frame_type      = ftype_code;
                    push.item.value_x         = {payload_reg[1], payload_reg[0]};
                    push.item.value_y         = {payload_reg[3], payload_reg[2]};
                    push.item.value_z         = {payload_reg[5], payload_reg[4]};
                    push.item.temperature_raw = {payload_reg[7], payload_reg[6]};
                end
                else
                begin
                    aligned_next     = 1'b0;
                    push.item.status = ST_TYPE_ERR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aligned_reg <= 1'b0;
            pos_reg     <= '0;
            sum_reg     <= '0;
            type_reg    <= '0;
        end
        else
        begin
            aligned_reg <= aligned_next;
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            type_reg    <= type_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            payload_reg[pay_idx] <= b;
        end
    end

    a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !aligned_reg |-> (pos_reg == '0) && (sum_reg == '0))
        else $error("hunting with stale position or sum");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_SUM)
        else $error("byte position beyond checksum byte");

    a_ok_stays: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && (push.item.status == ST_OK) |=> aligned_reg && (pos_reg == '0))
        else $error("good frame did not leave parser aligned at header");

endmodule : imu_fp_front

`default_nettype wire

FILE: rtl/imu_fp_queue.sv
// Short result queue between the front and back parts of the IMU frame parser.
// Depends on imu_fp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imu_fp_queue
    import imu_fp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire res_push_t push,
    input  wire logic      pop,
    output logic           full,
    output logic           q_valid,
    output out_item_t      q_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    out_item_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push.valid, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("result pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("result popped from empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule : imu_fp_queue

`default_nettype wire

FILE: rtl/imu_fp_back.sv
// Back part of the IMU frame parser: output register that presents results downstream.
// Depends on imu_fp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imu_fp_back
    import imu_fp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_valid,
    input  wire out_item_t q_item,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    // Refill the output register when it is empty or being taken this cycle
    assign pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= q_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule : imu_fp_back

`default_nettype wire

FILE: rtl/imu_frame_parser_top.sv
// Top level of the IMU 11-byte frame parser: front, result queue and back part.
// Depends on imu_fp_pkg, imu_fp_front, imu_fp_queue and imu_fp_back.
//
// Usage:
//  - Input channel (in_valid / in_ready / in_item): one beat per received serial
//    byte (kind = byte) or per receive-error event (kind = error), which drops any
//    partial frame and sends the parser back to header hunting.
//  - Output channel (out_valid / out_ready / out_item): one beat per finished frame
//    (ok, checksum error, unknown type) and per missing header while aligned.
//    Axis and temperature values are little-endian signed counts, zero unless ok.
//  - Throughput: one input beat per cycle, sustained, for as long as the receiver
//    keeps up; the front part takes a byte in the same cycle it classifies it.
//  - Result path: the queue takes a result at the edge that accepts the completing
//    beat; the output register loads it from the queue when that register is empty
//    or being taken, and out_valid rises as it loads.
//  - Receiver stall: results wait in the queue (QUEUE_DEPTH entries plus the output
//    register); in_ready drops only when the queue is full.
//  - Reset: hunting for the header, queue empty, out_valid low.
`timescale 1ns / 1ps
`default_nettype none

module imu_frame_parser_top
    import imu_fp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    res_push_t push;
    logic      beat;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    out_item_t q_item;

    // Take a beat whenever the queue has room; a result-free byte never needs it,
    // but keeping ready independent of the byte value keeps the handshake simple.
    assign in_ready = !q_full;
    assign beat     = in_valid && in_ready;

    // Classify the byte and advance the frame state
    imu_fp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .in_item (in_item),
        .push    (push)
    );

    // Hold results so front and back stall independently
    imu_fp_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (q_pop),
        .full    (q_full),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    // Present results downstream from a register
    imu_fp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule : imu_frame_parser_top

`default_nettype wire

FILE: tb/imu_frame_parser_top_test.sv
// Self-checking testbench for imu_frame_parser_top: directed stimulus table, then random frame traffic.
// Depends on imu_fp_pkg and the RTL under rtl/; results are checked against an in-bench frame predictor.
`timescale 1ns / 1ps

module imu_frame_parser_top_test;
    import imu_fp_pkg::*;

    localparam int RANDOM_BEATS = 1050;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    imu_frame_parser_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // One row of the directed table: the beat to send and, where it is obvious,
    // the frame result it must produce.
    typedef struct {
        in_item_t  beat;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    dir_row_t  dir_rows[$];
    out_item_t frames_due[$];   // results still owed by the parser, oldest first
    int        faults;
    int        live_beats;      // beats that the parser does not simply discard
    bit        calm;            // while set, neither side idles

    // Frame tracker state: mirrors what the parser must remember between beats.
    bit         synced;
    logic [3:0] frame_pos;
    logic [7:0] frame_sum;
    logic [7:0] frame_type_byte;
    logic [7:0] frame_payload [8];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic out_item_t mk_result(input logic [1:0] st, input logic [1:0] ft,
                                            input int x, input int y, input int z,
                                            input int t);
        out_item_t r;
        r.status          = st;
        r.frame_type      = ft;
        r.value_x         = 16'(x);
        r.value_y         = 16'(y);
        r.value_z         = 16'(z);
        r.temperature_raw = 16'(t);
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // Payload bytes with a bias towards the sign and range extremes.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_item_t mk_beat(input logic k, input logic [7:0] b);
        in_item_t it;
        it.kind    = k;
        it.rx_byte = b;
        return it;
    endfunction

    task automatic add_row(input logic k, input logic [7:0] b, input bit typed,
                           input out_item_t want);
        dir_row_t row;
        row.beat  = mk_beat(k, b);
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic note_fault(input string msg);
        faults++;
        if (faults <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic drop_to_hunt();
        synced    = 1'b0;
        frame_pos = '0;
        frame_sum = '0;
    endtask

    // Advance the frame tracker by one accepted beat and work out the result it
    // completes, if any.
    task automatic track_frame(input in_item_t b, output bit made, output out_item_t res);
        made = 1'b0;
        res  = '0;
        if (b.kind == KIND_ERROR)
        begin
            drop_to_hunt();
        end
        else if (!synced)
        begin
            if (b.rx_byte == HDR_BYTE)
            begin
                synced    = 1'b1;
                frame_pos = POS_TYPE;
                frame_sum = HDR_BYTE;
            end
        end
        else if (frame_pos == '0)
        begin
            // Aligned and waiting for the next header; any other byte is a header error.
            if (b.rx_byte == HDR_BYTE)
            begin
                frame_pos = POS_TYPE;
                frame_sum = HDR_BYTE;
            end
            else
            begin
                drop_to_hunt();
                made       = 1'b1;
                res.status = ST_HDR_ERR;
            end
        end
        else if (frame_pos == POS_TYPE)
        begin
            frame_type_byte = b.rx_byte;
            frame_sum       = frame_sum + b.rx_byte;
            frame_pos       = POS_DATA0;
        end
        else if (frame_pos <= POS_LAST)
        begin
            frame_payload[3'(frame_pos - POS_DATA0)] = b.rx_byte;
            frame_sum = frame_sum + b.rx_byte;
            frame_pos = frame_pos + 4'd1;
        end
        else
        begin
            made = 1'b1;
            if (frame_sum != b.rx_byte)
            begin
                drop_to_hunt();
                res.status = ST_SUM_ERR;
            end
            else if (frame_type_byte == TYPE_ACCEL || frame_type_byte == TYPE_OMEGA ||
                     frame_type_byte == TYPE_ANGLE)
            begin
                // Good frame: stay aligned and expect the next header.
                frame_pos           = '0;
                frame_sum           = '0;
                res.status          = ST_OK;
                res.frame_type      = 2'(frame_type_byte - TYPE_ACCEL);
                res.value_x         = {frame_payload[1], frame_payload[0]};
                res.value_y         = {frame_payload[3], frame_payload[2]};
                res.value_z         = {frame_payload[5], frame_payload[4]};
                res.temperature_raw = {frame_payload[7], frame_payload[6]};
            end
            else
            begin
                drop_to_hunt();
                res.status = ST_TYPE_ERR;
            end
        end
    endtask

    // Present one input beat after a random gap and hold it until accepted.
    // Called at a rising edge; returns at the edge that accepts the beat.
    task automatic send_beat(input in_item_t b, input bit typed, input out_item_t want);
        int        gap;
        bit        made;
        out_item_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (synced || (b.kind == KIND_BYTE && b.rx_byte == HDR_BYTE))
            live_beats++;
        track_frame(b, made, res);
        if (typed)
            frames_due.push_back(want);
        else if (made)
            frames_due.push_back(res);
    endtask

    // Send a complete 11-byte frame with random payload; optionally spoil the checksum.
    task automatic send_frame(input logic [7:0] type_b, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = HDR_BYTE + type_b;
        send_beat(mk_beat(KIND_BYTE, HDR_BYTE), 1'b0, '0);
        send_beat(mk_beat(KIND_BYTE, type_b), 1'b0, '0);
        repeat (8)
        begin
            b   = rand_byte();
            sum = sum + b;
            send_beat(mk_beat(KIND_BYTE, b), 1'b0, '0);
        end
        if (bad_sum)
            sum = sum + 8'($urandom_range(1, 255));
        send_beat(mk_beat(KIND_BYTE, sum), 1'b0, '0);
    endtask

    // Result side: check every accepted beat, then stall at random.
    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    note_fault($sformatf("unexpected result: status %0d type %0d",
                                         out_item.status, out_item.frame_type));
                end
                else
                begin
                    out_item_t exp_r;
                    exp_r = frames_due.pop_front();
                    if (out_item.status !== exp_r.status ||
                        out_item.frame_type !== exp_r.frame_type ||
                        out_item.value_x !== exp_r.value_x ||
                        out_item.value_y !== exp_r.value_y ||
                        out_item.value_z !== exp_r.value_z ||
                        out_item.temperature_raw !== exp_r.temperature_raw)
                        note_fault($sformatf({"mismatch: exp st %0d ft %0d x %0d y %0d z %0d",
                                              " t %0d / got st %0d ft %0d x %0d y %0d z %0d",
                                              " t %0d"},
                                             exp_r.status, exp_r.frame_type, exp_r.value_x,
                                             exp_r.value_y, exp_r.value_z,
                                             exp_r.temperature_raw, out_item.status,
                                             out_item.frame_type, out_item.value_x,
                                             out_item.value_y, out_item.value_z,
                                             out_item.temperature_raw));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Stimulus side.
    initial
    begin : stimulus_side
        logic [7:0] t;
        int         k;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        faults     = 0;
        live_beats = 0;
        calm       = 1'b0;
        synced     = 1'b0;
        frame_pos  = '0;
        frame_sum  = '0;
        frame_type_byte = '0;
        foreach (frame_payload[i])
            frame_payload[i] = '0;

        // Directed table.
        // Receive-error event straight after reset; the byte field is ignored.
        add_row(KIND_ERROR, HDR_BYTE, 1'b0, '0);
        // Good acceleration frame: x = -32768, y = 32767, z = -1, temperature 0.
        add_row(KIND_BYTE, HDR_BYTE, 1'b0, '0);
        add_row(KIND_BYTE, TYPE_ACCEL, 1'b0, '0);
        add_row(KIND_BYTE, 8'h00, 1'b0, '0);
        add_row(KIND_BYTE, 8'h80, 1'b0, '0);
        add_row(KIND_BYTE, 8'hFF, 1'b0, '0);
        add_row(KIND_BYTE, 8'h7F, 1'b0, '0);
        add_row(KIND_BYTE, 8'hFF, 1'b0, '0);
        add_row(KIND_BYTE, 8'hFF, 1'b0, '0);
        add_row(KIND_BYTE, 8'h00, 1'b0, '0);
        add_row(KIND_BYTE, 8'h00, 1'b0, '0);
        add_row(KIND_BYTE, 8'hA2, 1'b1, mk_result(ST_OK, 2'd0, -32768, 32767, -1, 0));
        // Still aligned, so a non-header byte is a header error and starts the hunt.
        add_row(KIND_BYTE, 8'h00, 1'b1, mk_result(ST_HDR_ERR, 2'd0, 0, 0, 0, 0));
        // Hunting: drop a stray byte.
        add_row(KIND_BYTE, 8'hFF, 1'b0, '0);
        // Unknown type byte with a correct checksum.
        add_row(KIND_BYTE, HDR_BYTE, 1'b0, '0);
        repeat (9)
            add_row(KIND_BYTE, 8'hFF, 1'b0, '0);
        add_row(KIND_BYTE, 8'h4C, 1'b1, mk_result(ST_TYPE_ERR, 2'd0, 0, 0, 0, 0));

        // Hold reset, then release it at an edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

        // Random traffic: mostly whole frames with random content, the rest broken
        // frames, noise and error events. Flip the calm flag now and then so that
        // some stretches run with no idling at all.
        live_beats = 0;
        while (live_beats < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 29) == 0)
                calm = ~calm;
            case ($urandom_range(0, 99)) inside
                [0:54]:
                begin
                    case ($urandom_range(0, 2))
                        0: send_frame(TYPE_ACCEL, 1'b0);
                        1: send_frame(TYPE_OMEGA, 1'b0);
                        default: send_frame(TYPE_ANGLE, 1'b0);
                    endcase
                end
                [55:64]:
                    send_frame(8'(TYPE_ACCEL + $urandom_range(0, 2)), 1'b1);
                [65:72]:
                begin
                    do
                        t = 8'($urandom);
                    while (t == TYPE_ACCEL || t == TYPE_OMEGA || t == TYPE_ANGLE);
                    send_frame(t, 1'b0);
                end
                [73:80]:
                begin
                    // Partial frame cut short by a receive error.
                    send_beat(mk_beat(KIND_BYTE, HDR_BYTE), 1'b0, '0);
                    k = $urandom_range(0, 9);
                    repeat (k)
                        send_beat(mk_beat(KIND_BYTE, rand_byte()), 1'b0, '0);
                    send_beat(mk_beat(KIND_ERROR, 8'($urandom)), 1'b0, '0);
                end
                [81:88]:
                begin
                    // Noise, with the odd header byte mixed in.
                    k = $urandom_range(1, 6);
                    repeat (k)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            t = HDR_BYTE;
                        else
                            t = 8'($urandom);
                        send_beat(mk_beat(KIND_BYTE, t), 1'b0, '0);
                    end
                end
                [89:94]:
                    send_beat(mk_beat(KIND_ERROR, 8'($urandom)), 1'b0, '0);
                default:
                begin
                    do
                        t = 8'($urandom);
                    while (t == HDR_BYTE);
                    send_beat(mk_beat(KIND_BYTE, t), 1'b0, '0);
                end
            endcase
        end
        in_valid <= 1'b0;
        calm     = 1'b0;

        // Wait for every owed result, then a few more cycles to catch strays.
        while (frames_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/imu_fp_pkg.sv
rtl/imu_fp_front.sv
rtl/imu_fp_queue.sv
rtl/imu_fp_back.sv
rtl/imu_frame_parser_top.sv
tb/imu_frame_parser_top_test.sv
